@@ sv/compass_heading_from_axes_core_defines.svh @@
// assertion macros for the compass heading core checker
// no dependencies; included by the checker file only
`ifndef COMPASS_HEADING_FROM_AXES_CORE_DEFINES_SVH
`define COMPASS_HEADING_FROM_AXES_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define CHC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("chc assertion failed");

// property checked on every clock edge, reset included
`define CHC_ASSERT_RST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("chc reset assertion failed");

`endif

@@ sv/chc_pkg.sv @@
// shared types, constants and arctangent table for the compass heading core
// no dependencies; used by every chc module
package chc_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int CORDIC_STAGES   = 20;

  localparam int TABLE_FRAC = 32;
  localparam int TABLE_LEN  = 32;
  localparam int SCALE_BITS = 32;

  // 17-bit magnitude after half-turn fold, scaled, plus growth headroom
  localparam int DATA_W  = 17 + SCALE_BITS + 3;
  localparam int Z_W     = ANGLE_FRAC_BITS + 2;
  localparam int ZU_W    = ANGLE_FRAC_BITS + 1;
  localparam int SHIFT_W = $clog2(CORDIC_STAGES);
  localparam int HEAD_W  = 12;
  localparam int PROD_W  = ZU_W + HEAD_W;
  localparam int HSUM_W  = PROD_W - ANGLE_FRAC_BITS;

  localparam logic [HEAD_W-1:0] TENTHS_PER_TURN = 12'd3600;
  localparam logic [HEAD_W-1:0] HEAD_MAX        = 12'd3599;
  localparam logic [HEAD_W-1:0] HEAD_POS_X      = 12'd0;
  localparam logic [HEAD_W-1:0] HEAD_POS_Y      = 12'd900;
  localparam logic [HEAD_W-1:0] HEAD_NEG_X      = 12'd1800;
  localparam logic [HEAD_W-1:0] HEAD_NEG_Y      = 12'd2700;

  localparam logic signed [Z_W-1:0] TURN      = Z_W'(1) << ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(1) << (ANGLE_FRAC_BITS - 1);

  // atan(2^-i) in turns, 32 fraction bits
  localparam logic [TABLE_FRAC-1:0] ATAN_TURNS_Q32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // one beat in flight through the pipeline
  typedef struct packed {
    logic                     special;
    logic [HEAD_W-1:0]        special_val;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [Z_W-1:0]    z;
  } item_t;

  // table entry rounded to the angle precision
  function automatic logic signed [Z_W-1:0] table_angle(input int unsigned idx);
    logic [TABLE_FRAC:0] e;
    logic [TABLE_FRAC:0] r;
    e = {1'b0, ATAN_TURNS_Q32[idx[4:0]]};
    if (TABLE_FRAC == ANGLE_FRAC_BITS) begin
      r = e;
    end else begin
      r = (e + ((TABLE_FRAC + 1)'(1) << (TABLE_FRAC - ANGLE_FRAC_BITS - 1)))
          >> (TABLE_FRAC - ANGLE_FRAC_BITS);
    end
    return Z_W'(r);
  endfunction

endpackage

@@ sv/chc_front.sv @@
// input stage: masks failed reads, flags axis cases, folds left half-plane
// depends on chc_pkg
module chc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  axis_x,
  input  logic signed [15:0]  axis_y,
  input  logic                read_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output chc_pkg::item_t      out_item
);

  logic           valid;
  chc_pkg::item_t item;
  chc_pkg::item_t item_next;

  logic signed [15:0] xm;
  logic signed [15:0] ym;
  logic signed [16:0] xe;
  logic signed [16:0] ye;
  logic signed [16:0] xf;
  logic signed [16:0] yf;
  logic               x_neg;

  always_comb begin
    xm    = read_ok ? axis_x : '0;
    ym    = read_ok ? axis_y : '0;
    x_neg = xm[15];
    xe    = {xm[15], xm};
    ye    = {ym[15], ym};
    xf    = x_neg ? -xe : xe;
    yf    = x_neg ? -ye : ye;

    item_next.x = {{(chc_pkg::DATA_W - 17 - chc_pkg::SCALE_BITS){xf[16]}}, xf,
                   {chc_pkg::SCALE_BITS{1'b0}}};
    item_next.y = {{(chc_pkg::DATA_W - 17 - chc_pkg::SCALE_BITS){yf[16]}}, yf,
                   {chc_pkg::SCALE_BITS{1'b0}}};
    item_next.z = x_neg ? chc_pkg::HALF_TURN : '0;

    // on an axis the heading is exact, no iterations needed
    if (ym == '0) begin
      item_next.special     = 1'b1;
      item_next.special_val = x_neg ? chc_pkg::HEAD_NEG_X : chc_pkg::HEAD_POS_X;
    end else if (xm == '0) begin
      item_next.special     = 1'b1;
      item_next.special_val = ym[15] ? chc_pkg::HEAD_NEG_Y : chc_pkg::HEAD_POS_Y;
    end else begin
      item_next.special     = 1'b0;
      item_next.special_val = chc_pkg::HEAD_POS_X;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

@@ sv/chc_stage.sv @@
// one vectoring cordic iteration with its pipeline register
// depends on chc_pkg
module chc_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  chc_pkg::item_t                     in_item,
  input  logic [chc_pkg::SHIFT_W-1:0]        shift,
  input  logic signed [chc_pkg::Z_W-1:0]     step_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output chc_pkg::item_t                     out_item
);

  logic           valid;
  chc_pkg::item_t item;
  chc_pkg::item_t item_next;

  logic signed [chc_pkg::DATA_W-1:0] xs;
  logic signed [chc_pkg::DATA_W-1:0] ys;
  logic signed [chc_pkg::DATA_W-1:0] dx;
  logic signed [chc_pkg::DATA_W-1:0] dy;
  logic                              y_pos;

  always_comb begin
    xs    = in_item.x;
    ys    = in_item.y;
    dx    = ys >>> shift;
    dy    = xs >>> shift;
    y_pos = !ys[chc_pkg::DATA_W-1] && (ys != '0);

    item_next             = in_item;
    if (y_pos) begin
      item_next.x = xs + dx;
      item_next.y = ys - dy;
      item_next.z = in_item.z + step_angle;
    end else begin
      item_next.x = xs - dx;
      item_next.y = ys + dy;
      item_next.z = in_item.z - step_angle;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

@@ sv/chc_back.sv @@
// angle wrap, scaling to tenths with saturation, output register
// depends on chc_pkg
module chc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  chc_pkg::item_t                    in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [chc_pkg::HEAD_W-1:0]        heading_tenths
);

  // wrap stage
  logic                             a_valid;
  logic                             a_special;
  logic [chc_pkg::HEAD_W-1:0]       a_special_val;
  logic [chc_pkg::ZU_W-1:0]         a_z;
  logic [chc_pkg::ZU_W-1:0]         a_z_next;
  logic                             a_ready;
  logic signed [chc_pkg::Z_W-1:0]   zw;

  // scale stage
  logic                             valid;
  logic [chc_pkg::HEAD_W-1:0]       heading;
  logic [chc_pkg::HEAD_W-1:0]       heading_next;
  logic                             b_ready;
  logic [chc_pkg::PROD_W-1:0]       prod;
  logic [chc_pkg::HSUM_W-1:0]       h;

  always_comb begin
    zw = in_item.z;
    if (zw < 0) begin
      zw = zw + chc_pkg::TURN;
    end
    if (zw < 0) begin
      zw = '0;
    end
    a_z_next = zw[chc_pkg::ZU_W-1:0];
  end

  always_comb begin
    prod = chc_pkg::PROD_W'(a_z) * chc_pkg::PROD_W'(chc_pkg::TENTHS_PER_TURN);
    h    = prod[chc_pkg::PROD_W-1:chc_pkg::ANGLE_FRAC_BITS];
    if (a_special) begin
      heading_next = a_special_val;
    end else if (h > chc_pkg::HSUM_W'(chc_pkg::HEAD_MAX)) begin
      heading_next = chc_pkg::HEAD_MAX;
    end else begin
      heading_next = h[chc_pkg::HEAD_W-1:0];
    end
  end

  assign b_ready        = !valid || out_ready;
  assign a_ready        = !a_valid || b_ready;
  assign in_ready       = a_ready;
  assign out_valid      = valid;
  assign heading_tenths = heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      valid   <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_special     <= in_item.special;
      a_special_val <= in_item.special_val;
      a_z           <= a_z_next;
    end
    if (a_valid && b_ready) begin
      heading <= heading_next;
    end
  end

endmodule

@@ sv/compass_heading_from_axes_core.sv @@
// a beat is registered in the input stage, in one register per cordic iteration, then in the wrap and output registers
// throughput: one beat per cycle while the output is not stalled, set by one register per cordic iteration
// back-pressure stalls only the stages that are full, so bubbles close up
// reset (rst, synchronous) clears every stage valid bit; data registers keep stale values
// depends on chc_pkg, chc_front, chc_stage, chc_back
module compass_heading_from_axes_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           axis_x,
  input  logic signed [15:0]           axis_y,
  input  logic                         read_ok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [chc_pkg::HEAD_W-1:0]   heading_tenths
);

  // link k carries the beat leaving stage k-1; link 0 leaves the input stage
  logic           st_valid [chc_pkg::CORDIC_STAGES+1];
  logic           st_ready [chc_pkg::CORDIC_STAGES+1];
  chc_pkg::item_t st_item  [chc_pkg::CORDIC_STAGES+1];

  // failed reads become the zero vector, axis cases are flagged,
  // and a vector in the left half-plane is turned through half a turn
  chc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .read_ok   (read_ok),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_item  (st_item[0])
  );

  // unrolled vectoring iterations, each with a fixed shift and table angle
  genvar i;
  generate
    for (i = 0; i < chc_pkg::CORDIC_STAGES; i++) begin : g_iter
      chc_stage u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_valid   (st_valid[i]),
        .in_ready   (st_ready[i]),
        .in_item    (st_item[i]),
        .shift      (chc_pkg::SHIFT_W'(i)),
        .step_angle (chc_pkg::table_angle(i)),
        .out_valid  (st_valid[i+1]),
        .out_ready  (st_ready[i+1]),
        .out_item   (st_item[i+1])
      );
    end
  endgenerate

  // negative angles wrap by one turn, then scale to tenths, truncate, saturate
  chc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (st_valid[chc_pkg::CORDIC_STAGES]),
    .in_ready       (st_ready[chc_pkg::CORDIC_STAGES]),
    .in_item        (st_item[chc_pkg::CORDIC_STAGES]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .heading_tenths (heading_tenths)
  );

endmodule

@@ sv/chc_checker.sv @@
// port-level checks on the compass heading core, bound to the top level
// depends on chc_pkg and compass_heading_from_axes_core_defines.svh
`include "compass_heading_from_axes_core_defines.svh"

module chc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [chc_pkg::HEAD_W-1:0]   heading_tenths
);

  // a stalled result beat holds
  `CHC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(heading_tenths))
  // headings never leave the 0..3599 range
  `CHC_ASSERT(a_out_range, clk, rst, out_valid |-> heading_tenths <= chc_pkg::HEAD_MAX)
  // a free output slot frees every stage back to the input
  `CHC_ASSERT(a_in_free, clk, rst, (out_ready || !out_valid) |-> in_ready)
  // reset empties the pipeline
  `CHC_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind compass_heading_from_axes_core chc_checker u_chc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .heading_tenths (heading_tenths)
);
